@@ src/euler_angles_to_rotation_matrix_assert.svh @@
// Assertion macros for the Euler-angle rotation block.
// Depends on nothing; included by the top level.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_ASSERT_SVH
`ifndef SYNTHESIS
`define EAR_ASSERT(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EAR_ASSERT_NR(label, clk, prop, msg) \
label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EAR_ASSERT(label, clk, rst_n, prop, msg)
`define EAR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ src/ear_pkg.sv @@
// Package for the Euler-angle rotation block: formats, CORDIC table, codes.
// No dependencies.
`default_nettype none
package ear_pkg;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int OUT_BITS_DEF = 16;
	localparam int TRIG_ITER_DEF = 14;
	localparam int ZW = 34;
	localparam int XW = 33;
	localparam int TW = 22;
	localparam logic [33:0] PI_Q30 = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [32:0] GAIN_Q30 = 33'd652032874;
	localparam logic [1:0] CONV_ZYZ = 2'd0;
	localparam logic [1:0] CONV_XYZ = 2'd1;
	localparam logic [1:0] CONV_ZYX = 2'd2;
	localparam logic [0:0] REG_CONVENTION = 1'b0;

	function automatic logic signed [33:0] atan_step(input int i);
		logic signed [33:0] r;
		begin
			case (i)
				0: r = 34'sd843314856;
				1: r = 34'sd497837829;
				2: r = 34'sd263043836;
				3: r = 34'sd133525158;
				4: r = 34'sd67021686;
				5: r = 34'sd33543515;
				6: r = 34'sd16775850;
				7: r = 34'sd8388437;
				8: r = 34'sd4194282;
				9: r = 34'sd2097149;
				default: r = (34'sd1 <<< (30 - i)) - 34'sd1;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

@@ src/ear_if.sv @@
// Valid/ready channel interface carrying a payload struct.
// Depends on nothing; payload type set by parameter.
`default_nettype none
interface ear_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/ear_cordic.sv @@
// Pipelined rotation-mode CORDIC: sine and cosine in Q.20 of one angle.
// Depends on ear_pkg.
`default_nettype none
module ear_cordic #(
	parameter int ANGLE_BITS = ear_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_ITERATIONS = ear_pkg::TRIG_ITER_DEF
) (
	input wire logic clk,
	input wire logic [TRIG_ITERATIONS+1:0] adv,
	input wire logic signed [ANGLE_BITS-1:0] angle,
	output logic signed [ear_pkg::TW-1:0] sin_q,
	output logic signed [ear_pkg::TW-1:0] cos_q
);
	import ear_pkg::*;
	localparam int N = TRIG_ITERATIONS;
	logic signed [ZW-1:0] z_s [0:N];
	logic signed [XW-1:0] x_s [0:N];
	logic signed [XW-1:0] y_s [0:N];
	logic flip_s [0:N];
	logic signed [ZW-1:0] z_in;
	logic signed [XW-1:0] x_fin;
	logic signed [XW-1:0] y_fin;

	assign z_in = ZW'(angle) <<< (33 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_s[0] <= $signed(GAIN_Q30);
			y_s[0] <= '0;
			if (z_in > $signed(HALF_PI_Q30)) begin
				z_s[0] <= z_in - $signed(PI_Q30);
				flip_s[0] <= 1'b1;
			end else if (z_in < -$signed(HALF_PI_Q30)) begin
				z_s[0] <= z_in + $signed(PI_Q30);
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0] <= z_in;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_step(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_step(i);
				end
			end
		end
	end

	assign x_fin = flip_s[N] ? -x_s[N] : x_s[N];
	assign y_fin = flip_s[N] ? -y_s[N] : y_s[N];

	always_ff @(posedge clk) begin
		if (adv[N+1]) begin
			cos_q <= TW'((x_fin + XW'(512)) >>> 10);
			sin_q <= TW'((y_fin + XW'(512)) >>> 10);
		end
	end
endmodule
`default_nettype wire

@@ src/euler_angles_to_rotation_matrix.sv @@
// Depth: TRIG_ITERATIONS + 6 register stages, from the CORDIC input register
// to the output register.
// Throughput: one word per cycle; CORDIC stages, two multiply stages,
// sum/round stage and the output register all advance together.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears valid bits and convention to z-y-z.
`default_nettype none
`include "euler_angles_to_rotation_matrix_assert.svh"
module euler_angles_to_rotation_matrix #(
	parameter int ANGLE_BITS = ear_pkg::ANGLE_BITS_DEF,
	parameter int OUT_BITS = ear_pkg::OUT_BITS_DEF,
	parameter int TRIG_ITERATIONS = ear_pkg::TRIG_ITER_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ear_if.sink in_ch,
	ear_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ear_pkg::*;
	localparam int N = TRIG_ITERATIONS;
	// stages: N+2 cordic, product1, product2, sum/round, output
	localparam int NS = N + 6;
	localparam int SH = 60 - (OUT_BITS - 2);
	localparam int PW = 66;

	logic [1:0] convention_q;
	logic [NS-1:0] vld_s;
	logic [NS-1:0] adv;
	logic [1:0] conv_s [0:NS-1];
	logic signed [TW-1:0] s [0:2];
	logic signed [TW-1:0] c [0:2];
	logic signed [2*TW-1:0] ss1_s, sc1_s, cs1_s, cc1_s;
	logic signed [TW-1:0] k0_s, k1_s, k2_s, k3_s;
	logic signed [TW-1:0] r0_s, r1_s;
	logic signed [PW-1:0] p_s [0:8];
	logic signed [OUT_BITS-1:0] o_s [0:8];
	logic signed [PW-1:0] t [0:8];

	// control: pipeline advances from the tail when out is free
	assign pready = 1'b1;
	assign prdata = {30'd0, convention_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			convention_q <= CONV_ZYZ;
		end else if (psel && penable && pwrite && paddr[2] == REG_CONVENTION) begin
			convention_q <= pwdata[1:0];
		end
	end

	always_comb begin
		adv[NS-1] = !vld_s[NS-1] || out_ch.ready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = adv[i+1];
		end
	end
	assign in_ch.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv[0]) begin
			vld_s <= {vld_s[NS-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			conv_s[0] <= convention_q;
			for (int i = 1; i < NS; i++) conv_s[i] <= conv_s[i-1];
		end
	end

	ear_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(N)) u_c0 (
		.clk, .adv(adv[N+1:0]), .angle(in_ch.data.angle_first), .sin_q(s[0]), .cos_q(c[0]));
	ear_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(N)) u_c1 (
		.clk, .adv(adv[N+1:0]), .angle(in_ch.data.angle_second), .sin_q(s[1]), .cos_q(c[1]));
	ear_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(N)) u_c2 (
		.clk, .adv(adv[N+1:0]), .angle(in_ch.data.angle_third), .sin_q(s[2]), .cos_q(c[2]));

	// first products: pair the middle angle with the one it multiplies
	// twice, keep the others for the second product stage
	always_ff @(posedge clk) begin
		if (adv[N+2]) begin
			case (conv_s[N+1])
				CONV_XYZ: begin
					// outer angle 0 times middle, rest pairs with angle 2
					ss1_s <= s[0] * s[1]; sc1_s <= s[0] * c[1];
					cs1_s <= c[0] * s[1]; cc1_s <= c[0] * c[1];
				end
				default: begin
					ss1_s <= s[0] * s[1]; sc1_s <= s[0] * c[1];
					cs1_s <= c[0] * s[1]; cc1_s <= c[0] * c[1];
				end
			endcase
			k0_s <= s[2]; k1_s <= c[2]; k2_s <= s[0]; k3_s <= c[0];
			r0_s <= s[1]; r1_s <= c[1];
		end
	end

	// second products, all to Q.60; widen first so the triple product keeps its top bits
	logic signed [PW-1:0] a_ss2, a_ss2c, a_cs2, a_cs2c, a_cc2, a_cc2c, a_sc2, a_sc2c;
	logic signed [PW-1:0] q0s, q0c, q1s, q1c, q2s, q2c;
	assign a_ss2 = PW'(ss1_s) * PW'(k0_s); assign a_ss2c = PW'(ss1_s) * PW'(k1_s);
	assign a_cs2 = PW'(cs1_s) * PW'(k0_s); assign a_cs2c = PW'(cs1_s) * PW'(k1_s);
	assign a_sc2 = PW'(sc1_s) * PW'(k0_s); assign a_sc2c = PW'(sc1_s) * PW'(k1_s);
	assign a_cc2 = PW'(cc1_s) * PW'(k0_s); assign a_cc2c = PW'(cc1_s) * PW'(k1_s);
	assign q0s = PW'(k2_s * k0_s) <<< 20; assign q0c = PW'(k2_s * k1_s) <<< 20;
	assign q1s = PW'(k3_s * k0_s) <<< 20; assign q1c = PW'(k3_s * k1_s) <<< 20;
	assign q2s = PW'(r1_s * k0_s) <<< 20; assign q2c = PW'(r1_s * k1_s) <<< 20;

	always_comb begin
		for (int k = 0; k < 9; k++) t[k] = '0;
		case (conv_s[N+2])
			CONV_XYZ: begin
				t[0] = q2c; t[1] = -q2s; t[2] = PW'(r0_s) <<< 40;
				t[3] = q1s + a_ss2c; t[4] = q1c - a_ss2;
				t[5] = -(PW'(sc1_s) <<< 20);
				t[6] = -a_cs2c + q0s; t[7] = a_cs2 + q0c;
				t[8] = PW'(cc1_s) <<< 20;
			end
			CONV_ZYX: begin
				t[0] = PW'(cc1_s) <<< 20; t[1] = a_cs2 - q0c; t[2] = a_cs2c + q0s;
				t[3] = PW'(sc1_s) <<< 20; t[4] = a_ss2 + q1c; t[5] = a_ss2c - q1s;
				t[6] = -(PW'(r0_s) <<< 40); t[7] = q2s; t[8] = q2c;
			end
			default: begin
				t[0] = a_cc2c - q0s; t[1] = -a_cc2 - q0c; t[2] = PW'(cs1_s) <<< 20;
				t[3] = a_sc2c + q1s; t[4] = -a_sc2 + q1c; t[5] = PW'(ss1_s) <<< 20;
				t[6] = -(PW'(PW'(r0_s * k1_s)) <<< 20);
				t[7] = PW'(PW'(r0_s * k0_s)) <<< 20; t[8] = PW'(r1_s) <<< 40;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[N+3]) for (int k = 0; k < 9; k++) p_s[k] <= t[k];
	end

	// round half up and saturate to +-one
	function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] r;
		logic signed [PW-1:0] one;
		begin
			one = PW'(1) <<< (OUT_BITS - 2);
			r = (v + $signed(PW'(1) <<< (SH - 1))) >>> SH;
			if (r > one) r = one;
			if (r < -one) r = -one;
			return OUT_BITS'(r);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv[N+4]) for (int k = 0; k < 9; k++) o_s[k] <= to_out(p_s[k]);
	end

	// final register stage holds the word until taken
	logic signed [OUT_BITS-1:0] f_s [0:8];
	always_ff @(posedge clk) begin
		if (adv[N+5]) for (int k = 0; k < 9; k++) f_s[k] <= o_s[k];
	end

	assign out_ch.valid = vld_s[NS-1];
	assign out_ch.data.r_row0_col0 = f_s[0];
	assign out_ch.data.r_row0_col1 = f_s[1];
	assign out_ch.data.r_row0_col2 = f_s[2];
	assign out_ch.data.r_row1_col0 = f_s[3];
	assign out_ch.data.r_row1_col1 = f_s[4];
	assign out_ch.data.r_row1_col2 = f_s[5];
	assign out_ch.data.r_row2_col0 = f_s[6];
	assign out_ch.data.r_row2_col1 = f_s[7];
	assign out_ch.data.r_row2_col2 = f_s[8];

	`EAR_ASSERT(a_stall_hold, clk, arst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "output word dropped during stall")
	`EAR_ASSERT(a_in_ready, clk, arst_n, in_ch.ready == (!out_ch.valid || out_ch.ready), "input ready out of step with output")
	`EAR_ASSERT(a_sat, clk, arst_n, out_ch.valid |-> f_s[4] <= $signed(OUT_BITS'(1) <<< (OUT_BITS - 2)) && f_s[4] >= -$signed(OUT_BITS'(1) <<< (OUT_BITS - 2)), "entry beyond one")
	`EAR_ASSERT_NR(a_reset, clk, !arst_n |=> vld_s == '0, "valid bits set in reset")
endmodule
`default_nettype wire

@@ sim/tb_types.sv @@
// Word layouts for the testbench channels: one angle triple in, one matrix out.
// Depends on nothing; compiled after the design package and before the top.
package tb_types;
	typedef struct packed {
		logic signed [15:0] angle_first;
		logic signed [15:0] angle_second;
		logic signed [15:0] angle_third;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] r_row0_col0;
		logic signed [15:0] r_row0_col1;
		logic signed [15:0] r_row0_col2;
		logic signed [15:0] r_row1_col0;
		logic signed [15:0] r_row1_col1;
		logic signed [15:0] r_row1_col2;
		logic signed [15:0] r_row2_col0;
		logic signed [15:0] r_row2_col1;
		logic signed [15:0] r_row2_col2;
	} matrix_t;
endpackage

@@ sim/tb_top.sv @@
// Testbench for the Euler-angle to rotation-matrix block: drives angle triples
// under every convention, predicts each matrix bit for bit and checks it.
// Depends on ear_pkg, ear_if, tb_types and the block itself.
module tb_top;
	import ear_pkg::*;
	import tb_types::*;

	localparam int SETTLE = 40;
	// pi/2 and pi in the Q3.13 input format
	localparam int HALF_PI_IN = 12868;
	localparam int PI_IN = 25736;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ear_if #(.payload_t(angles_t)) in_ch ();
	ear_if #(.payload_t(matrix_t)) out_ch ();

	euler_angles_to_rotation_matrix uut (
		.clk(clk), .arst_n(arst_n),
		.in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state and the matrices still to come out
	logic [1:0] conv_shadow;
	matrix_t pending_matrices[$];
	int errors;
	// receiver behavior: 0 always ready, 1 random stalls, 2 fixed pattern
	int stall_mode;
	int hold_cycles;
	int pattern_phase;
	// bursty sender: probability of a gap after each word, in percent
	int gap_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous limit: far beyond the slowest legal run
	initial begin
		#(20 * 600000);
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic longint cordic_atan(input int i);
		longint tab[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149};
		if (i < 10) return tab[i];
		return (64'sd1 <<< (30 - i)) - 1;
	endfunction

	// sine and cosine in Q.20 of one input angle
	task automatic trig_q20(input logic signed [15:0] ang, output longint s, output longint c);
		longint z, x, y, nx;
		bit flip;
		z = longint'(ang) * (64'sd1 <<< 17);
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < 14; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= cordic_atan(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += cordic_atan(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + 512) >>> 10;
		s = (y + 512) >>> 10;
	endtask

	// round a Q.60 sum to Q1.14 half up and clamp at plus or minus one
	function automatic logic signed [15:0] round_q14(input longint q60);
		longint r;
		r = (q60 + (64'sd1 <<< 45)) >>> 46;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r[15:0];
	endfunction

	task automatic predict_matrix(input angles_t a, output matrix_t m);
		longint s0, c0, s1, c1, s2, c2;
		longint t[9];
		longint k1, k2;
		trig_q20(a.angle_first, s0, c0);
		trig_q20(a.angle_second, s1, c1);
		trig_q20(a.angle_third, s2, c2);
		k2 = 64'sd1 <<< 20;
		k1 = 64'sd1 <<< 40;
		if (conv_shadow == CONV_XYZ) begin
			t[0] = c1 * c2 * k2;
			t[1] = -(c1 * s2 * k2);
			t[2] = s1 * k1;
			t[3] = c0 * s2 * k2 + s0 * s1 * c2;
			t[4] = c0 * c2 * k2 - s0 * s1 * s2;
			t[5] = -(s0 * c1 * k2);
			t[6] = -(c0 * s1 * c2) + s0 * s2 * k2;
			t[7] = c0 * s1 * s2 + c2 * s0 * k2;
			t[8] = c0 * c1 * k2;
		end else if (conv_shadow == CONV_ZYX) begin
			t[0] = c0 * c1 * k2;
			t[1] = c0 * s1 * s2 - s0 * c2 * k2;
			t[2] = c0 * s1 * c2 + s0 * s2 * k2;
			t[3] = s0 * c1 * k2;
			t[4] = s0 * s1 * s2 + c0 * c2 * k2;
			t[5] = s0 * s1 * c2 - c0 * s2 * k2;
			t[6] = -(s1 * k1);
			t[7] = c1 * s2 * k2;
			t[8] = c1 * c2 * k2;
		end else begin
			// z-y-z, also taken for the unused code 3
			t[0] = c0 * c1 * c2 - s0 * s2 * k2;
			t[1] = -(c0 * c1 * s2) - s0 * c2 * k2;
			t[2] = c0 * s1 * k2;
			t[3] = s0 * c1 * c2 + c0 * s2 * k2;
			t[4] = -(s0 * c1 * s2) + c0 * c2 * k2;
			t[5] = s0 * s1 * k2;
			t[6] = -(s1 * c2 * k2);
			t[7] = s1 * s2 * k2;
			t[8] = c1 * k1;
		end
		m.r_row0_col0 = round_q14(t[0]);
		m.r_row0_col1 = round_q14(t[1]);
		m.r_row0_col2 = round_q14(t[2]);
		m.r_row1_col0 = round_q14(t[3]);
		m.r_row1_col1 = round_q14(t[4]);
		m.r_row1_col2 = round_q14(t[5]);
		m.r_row2_col0 = round_q14(t[6]);
		m.r_row2_col1 = round_q14(t[7]);
		m.r_row2_col2 = round_q14(t[8]);
	endtask

	task automatic report(input int entry, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("mismatch entry r%0d%0d: got %0d want %0d", entry / 3, entry % 3,
			$signed(got), $signed(want));
	endtask

	// compare every accepted output word with the oldest prediction
	always @(posedge clk) begin
		matrix_t want;
		logic [143:0] g, w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_matrices.size() == 0) begin
				errors++;
				$display("unexpected output word");
			end else begin
				want = pending_matrices.pop_front();
				g = out_ch.data;
				w = want;
				for (int k = 0; k < 9; k++)
					if (g[(8 - k) * 16 +: 16] !== w[(8 - k) * 16 +: 16])
						report(k, g[(8 - k) * 16 +: 16], w[(8 - k) * 16 +: 16]);
			end
		end
	end

	// receiver: a long hold-off wins over the stall pattern
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			case (stall_mode)
				1: out_ch.ready <= ($urandom_range(99) >= 30);
				2: begin
					out_ch.ready <= (pattern_phase % 7) < 4;
				end
				default: out_ch.ready <= 1'b1;
			endcase
			pattern_phase <= pattern_phase + 1;
		end
	end

	// offer one word, hold it until taken, then record its prediction
	task automatic send_angles(input angles_t a);
		matrix_t m;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= a;
		do @(posedge clk); while (!in_ch.ready);
		predict_matrix(a, m);
		pending_matrices.push_back(m);
		// drop valid for a random gap now and then
		if ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(6)) @(negedge clk);
		end
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_matrices.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_convention(input logic [31:0] value);
		go_idle();
		apb_write(3'(4 * REG_CONVENTION), value);
		conv_shadow = value[1:0];
	endtask

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(HALF_PI_IN + $signed($urandom_range(4)) - 2);
			3: return 16'(-HALF_PI_IN + $signed($urandom_range(4)) - 2);
			4: return 16'(PI_IN + $signed($urandom_range(8)) - 4);
			5: return 16'(-PI_IN + $signed($urandom_range(8)) - 4);
			6: return 16'($signed($urandom_range(64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int n);
		angles_t a;
		repeat (n) begin
			a.angle_first = pick_angle();
			a.angle_second = pick_angle();
			a.angle_third = pick_angle();
			send_angles(a);
		end
	endtask

	// extremes, zero, the fold points near plus and minus pi/2 and pi
	task automatic test_directed();
		logic signed [15:0] v[8] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'(HALF_PI_IN),
			16'(HALF_PI_IN + 1), 16'(-HALF_PI_IN - 1), 16'(PI_IN), 16'(-PI_IN)};
		angles_t a;
		gap_pct = 0;
		stall_mode = 0;
		for (int i = 0; i < 8; i++) begin
			a.angle_first = v[i];
			a.angle_second = v[(i + 3) % 8];
			a.angle_third = v[(i + 5) % 8];
			send_angles(a);
		end
	endtask

	task automatic test_each_convention();
		for (int c = 0; c < 4; c++) begin
			set_convention(c);
			test_directed();
			stall_mode = 1 + (c % 2);
			gap_pct = 30;
			send_random(300);
		end
	endtask

	// hold the receiver off for a long stretch while words keep coming
	task automatic test_backpressure();
		set_convention(CONV_XYZ);
		gap_pct = 0;
		stall_mode = 0;
		@(negedge clk);
		hold_cycles = 200;
		send_random(80);
		stall_mode = 1;
		gap_pct = 50;
		send_random(150);
	endtask

	// a write to a register that does not exist changes nothing
	task automatic test_unused_address();
		set_convention(CONV_ZYX);
		apb_write(3'd4, 32'd1);
		send_random(30);
		// all bits set selects the unused code, taken as z-y-z
		set_convention(32'hFFFF_FFFF);
		send_random(60);
		set_convention(CONV_ZYZ);
		stall_mode = 2;
		gap_pct = 10;
		send_random(150);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		conv_shadow = CONV_ZYZ;
		errors = 0;
		stall_mode = 0;
		hold_cycles = 0;
		pattern_phase = 0;
		gap_pct = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value first, then every setting
		test_directed();
		test_each_convention();
		test_backpressure();
		test_unused_address();
		go_idle();

		if (errors == 0 && pending_matrices.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
